FILE: sv/bem_pkg.sv
// ---------------------------------------------------------------------------
// bem_pkg: shared types and constants of the binary edge marker
// Job record passed from the front to the back, register indexes, levels.
// ---------------------------------------------------------------------------
package bem_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned RESET_WIDTH  = 2048;
  localparam logic [15:0] RESET_HEIGHT = 16'd1080;

  // gray = sum/3 > 128  <=>  sum >= 387
  localparam logic [9:0] BIN_SUM_MIN = 10'd387;

  localparam logic [7:0] LEVEL_FULL = 8'hFF;
  localparam logic [7:0] LEVEL_EDGE = 8'h00;

  localparam int unsigned COL_OUT_W   = 11;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // one classified pixel, worth zero, one or two result beats
  typedef struct packed {
    logic                 lvl_full;  // interior result is 255
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;       // row of the pixel itself
    logic                 has_up;    // emits the pixel above
    logic                 has_own;   // last row: emits its own border pixel
    logic                 done;      // last column; an own pixel closes the frame
  } job_t;

endpackage

FILE: sv/bem_front.sv
// ---------------------------------------------------------------------------
// bem_front: pixel intake, binarizer and line buffer window
// Tracks position, binarizes each pixel, looks up the two buffered rows and
// classifies the pixel into a job for the back end.
// ---------------------------------------------------------------------------
module bem_front #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned CW        = $clog2(MAX_WIDTH),
  parameter int unsigned EW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [EW-1:0]        eff_width_i,
  input  logic [15:0]          eff_height_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output bem_pkg::job_t        q_job_o
);

  // line buffer entry: [1] row y-2 bit, [0] row y-1 bit
  logic [1:0] lb_mem [MAX_WIDTH];

  logic [CW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic          accept;

  logic          wrap_c;
  logic [16:0]   y0, y1;
  logic [15:0]   y;
  logic [CW-1:0] x, xr1;
  logic [EW-1:0] x1e;
  logic [9:0]    sum;
  logic          cur;

  logic          s2_v_q;
  logic [CW-1:0] s2_x_q, s2_x1_q;
  logic          s2_cur_q, s2_inside_q;
  bem_pkg::job_t s2_job_q;
  logic [1:0]    rd0_q, rd1_q;

  logic          wr_v_q;
  logic [CW-1:0] wr_addr_q;
  logic [1:0]    wr_data_q;
  logic          left_q;

  logic [1:0]    e0, e1;
  logic          above, edge_hit;

  assign s_axis_tready = !s2_v_q || !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_push_o      = s2_v_q && !q_full_i;

  // position of this pixel, wrapping a count left beyond a changed size
  always_comb begin
    wrap_c = EW'(col_q) >= eff_width_i;
    y0     = wrap_c ? ({1'b0, row_q} + 17'd1) : {1'b0, row_q};
    y      = (y0 >= {1'b0, eff_height_i}) ? 16'd0 : y0[15:0];
    x      = wrap_c ? '0 : col_q;
    x1e    = EW'(x) + EW'(1);
    y1     = {1'b0, y} + 17'd1;
    xr1    = (x == CW'(MAX_WIDTH - 1)) ? x : x + CW'(1);
    sum    = {2'b00, s_axis_tdata[7:0]} + {2'b00, s_axis_tdata[15:8]}
           + {2'b00, s_axis_tdata[23:16]};
    cur    = sum >= bem_pkg::BIN_SUM_MIN;
    if (x1e >= eff_width_i) begin
      col_d = '0;
      row_d = (y1 >= {1'b0, eff_height_i}) ? 16'd0 : y1[15:0];
    end else begin
      col_d = x1e[CW-1:0];
      row_d = y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s2_v_q <= 1'b0;
      wr_v_q <= 1'b0;
      left_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept) begin
        s2_v_q <= 1'b1;
      end else if (q_push_o) begin
        s2_v_q <= 1'b0;
      end
      if (q_push_o) begin
        wr_v_q <= 1'b1;
        left_q <= above;
      end
    end
  end

  // window stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_x_q            <= x;
      s2_x1_q           <= xr1;
      s2_cur_q          <= cur;
      s2_inside_q       <= (x != '0) && (x1e < eff_width_i) && (y >= 16'd2);
      s2_job_q.lvl_full <= 1'b0;
      s2_job_q.col      <= bem_pkg::COL_OUT_W'(x);
      s2_job_q.row      <= y;
      s2_job_q.has_up   <= y != 16'd0;
      s2_job_q.has_own  <= y1 == {1'b0, eff_height_i};
      s2_job_q.done     <= x1e == eff_width_i;
    end
    if (q_push_o) begin
      wr_addr_q <= s2_x_q;
      wr_data_q <= {above, s2_cur_q};
    end
  end

  // line buffer: registered reads at intake, write as the job leaves
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd0_q <= lb_mem[x];
      rd1_q <= lb_mem[xr1];
    end
    if (q_push_o) begin
      lb_mem[s2_x_q] <= {above, s2_cur_q};
    end
  end

  // forward the write that landed on the same edge as the read
  always_comb begin
    e0       = (wr_v_q && (wr_addr_q == s2_x_q))  ? wr_data_q : rd0_q;
    e1       = (wr_v_q && (wr_addr_q == s2_x1_q)) ? wr_data_q : rd1_q;
    above    = e0[0];
    edge_hit = (!left_q && e1[0]) || (!e0[1] && s2_cur_q);
    q_job_o          = s2_job_q;
    q_job_o.lvl_full = s2_inside_q && !edge_hit;
  end

endmodule

FILE: sv/bem_queue.sv
// ---------------------------------------------------------------------------
// bem_queue: short job queue between front and back
// Four-entry FIFO of classified pixels.
// ---------------------------------------------------------------------------
module bem_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bem_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bem_pkg::job_t head_o
);

  bem_pkg::job_t                    q_mem [bem_pkg::QUEUE_DEPTH];
  logic [bem_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [bem_pkg::QCNT_W-1:0]       cnt_q;

  assign full_o  = cnt_q == bem_pkg::QCNT_W'(bem_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= job_i;
    end
  end

endmodule

FILE: sv/bem_back.sv
// ---------------------------------------------------------------------------
// bem_back: result issue
// Expands each job into its result beats and holds them in the output
// register until the receiver takes them.
// ---------------------------------------------------------------------------
module bem_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  bem_pkg::job_t q_head_i,
  output logic          q_pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [39:0]   m_axis_tdata,   // level[7:0], out_col[18:8], out_row[34:19], zero
  output logic          m_axis_tlast    // frame_done
);

  logic                            out_v_q;
  logic [7:0]                      out_lvl_q;
  logic [bem_pkg::COL_OUT_W-1:0]   out_col_q, hold_col_q;
  logic [bem_pkg::ROW_W-1:0]       out_row_q, hold_row_q;
  logic                            out_last_q, hold_done_q;
  logic                            sec_q;
  logic                            load, silent;

  assign load    = !out_v_q || m_axis_tready;
  // a first-row job of a taller frame yields nothing: drop it at once
  assign silent  = !q_head_i.has_up && !q_head_i.has_own;
  assign q_pop_o = !sec_q && !q_empty_i && (silent || load);

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, out_row_q, out_col_q, out_lvl_q};
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sec_q   <= 1'b0;
    end else if (load) begin
      if (sec_q) begin
        out_v_q <= 1'b1;
        sec_q   <= 1'b0;
      end else if (!q_empty_i && !silent) begin
        out_v_q <= 1'b1;
        sec_q   <= q_head_i.has_up && q_head_i.has_own;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_q) begin
        out_lvl_q  <= bem_pkg::LEVEL_EDGE;
        out_col_q  <= hold_col_q;
        out_row_q  <= hold_row_q;
        out_last_q <= hold_done_q;
      end else if (!q_empty_i && !silent) begin
        out_col_q   <= q_head_i.col;
        hold_col_q  <= q_head_i.col;
        hold_row_q  <= q_head_i.row;
        hold_done_q <= q_head_i.done;
        if (q_head_i.has_up) begin
          out_lvl_q  <= q_head_i.lvl_full ? bem_pkg::LEVEL_FULL : bem_pkg::LEVEL_EDGE;
          out_row_q  <= q_head_i.row - 16'd1;
          out_last_q <= 1'b0;
        end else begin
          out_lvl_q  <= bem_pkg::LEVEL_EDGE;
          out_row_q  <= q_head_i.row;
          out_last_q <= q_head_i.done;
        end
      end
    end
  end

endmodule

FILE: sv/binary_edge_marker_core.sv
// ---------------------------------------------------------------------------
// binary_edge_marker_core: threshold binarizer with edge marking
// RGB pixels in raster order in, one binary edge map pixel per result out.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one RGB pixel per beat, raster order.
//   Master stream: one output pixel per beat with its column and row;
//   tlast marks the last pixel of the frame. Pixel (x,y) releases the
//   output for (x,y-1); pixels of the last row also release their own
//   border pixel. First-row pixels of a taller frame release nothing.
//   Configuration: frame_width (index 0) and frame_height (index 1), written
//   between frames while the block is idle.
// Timing:
//   A pixel is taken every cycle while the job queue is not full; each beat
//   passes the window stage, job queue and output register. Last-row pixels
//   of a taller frame carry two results, and the output register sets the pace.
//   Line buffer reads are registered and issued on the intake edge.
// Reset clears position counters, queue and output valid; the line buffer
// holds whatever it held until the first row overwrites it. When the
// receiver stalls, the output beat holds, the four-deep job queue fills and
// then tready drops.
// ---------------------------------------------------------------------------
module binary_edge_marker_core #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // level[7:0], out_col[18:8], out_row[34:19], zero
  output logic        m_axis_tlast    // frame_done
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RST_W =
    (bem_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : bem_pkg::RESET_WIDTH;

  logic [EW-1:0] eff_w_q, eff_w_d;
  logic [15:0]   eff_h_q, eff_h_d;
  logic [11:0]   w_raw;

  logic          q_full, q_push, q_pop, q_empty;
  bem_pkg::job_t q_job, q_head;

  // store effective sizes: zero reads as one, width takes bits [11:0] and saturates
  always_comb begin
    w_raw   = cfg_data_i[11:0];
    eff_w_d = eff_w_q;
    eff_h_d = eff_h_q;
    if (cfg_we_i) begin
      case (bem_pkg::cfg_reg_e'(cfg_idx_i))
        bem_pkg::REG_FRAME_WIDTH: begin
          if (w_raw == 12'd0) begin
            eff_w_d = EW'(1);
          end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
            eff_w_d = EW'(MAX_WIDTH);
          end else begin
            eff_w_d = EW'(w_raw);
          end
        end
        bem_pkg::REG_FRAME_HEIGHT: begin
          eff_h_d = (cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i;
        end
        default: begin
          eff_w_d = eff_w_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= EW'(RST_W);
      eff_h_q <= bem_pkg::RESET_HEIGHT;
    end else begin
      eff_w_q <= eff_w_d;
      eff_h_q <= eff_h_d;
    end
  end

  bem_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .EW        (EW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eff_width_i   (eff_w_q),
    .eff_height_i  (eff_h_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (q_job)
  );

  bem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  bem_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: sv/bem_checker.sv
// ---------------------------------------------------------------------------
// bem_checker: port-level checks of the binary edge marker
// Output levels are binary, padding is zero, frame end is a border pixel, beats hold on stall.
// ---------------------------------------------------------------------------
module bem_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_level_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'h00 || m_axis_tdata[7:0] == 8'hFF))
    else $error("output level is neither 0 nor 255");

  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("frame end beat is not a border pixel");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:35] == 5'b0))
    else $error("padding bits of output beat are not zero");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output beat changed while stalled");

endmodule

bind binary_edge_marker_core bem_checker u_bem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
